[src/chsc_pkg.sv]
// Package for the conveyor height sorter control: event and command codes,
// window sizes, threshold scaling and the result record.
// No dependencies.
package chsc_pkg;

  // Height profile windows
  localparam int unsigned OUTER_COUNT  = 40;
  localparam int unsigned MIDDLE_START = 60;
  localparam int unsigned MIDDLE_COUNT = 60;
  localparam int unsigned SAMPLE_BITS  = 12;

  // Fixed field widths
  localparam int unsigned OP_W    = 4;
  localparam int unsigned VALUE_W = 12;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CLS_W   = 2;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned SUM_W   = 18;
  localparam int unsigned WIN_W   = 9;

  localparam logic [COUNT_W-1:0] SAMPLE_LIMIT = 8'd200;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;
  localparam logic [SUM_W-1:0]   SUM_MAX      = {SUM_W{1'b1}};

  localparam logic [VALUE_W-1:0] SAMPLE_MASK =
    VALUE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  localparam logic [WIN_W-1:0] OUTER_END    = WIN_W'(OUTER_COUNT);
  localparam logic [WIN_W-1:0] MIDDLE_BEGIN = WIN_W'(MIDDLE_START);
  localparam logic [WIN_W-1:0] MIDDLE_END   = WIN_W'(MIDDLE_START + MIDDLE_COUNT);

  // Scaled thresholds: mean > lo  <=>  sum >= (lo+1)*N,  mean < hi  <=>  sum < hi*N
  localparam int unsigned MAX_COUNT = (OUTER_COUNT > MIDDLE_COUNT) ? OUTER_COUNT
                                                                   : MIDDLE_COUNT;
  localparam int unsigned SCALE_W = $clog2(4096 * MAX_COUNT + 1);
  localparam int unsigned THR_W   = (SCALE_W > SUM_W) ? SCALE_W : SUM_W;

  // Event codes
  localparam logic [OP_W-1:0] OP_START_BLOCKED = 4'd0;
  localparam logic [OP_W-1:0] OP_SORT_CLEAR    = 4'd1;
  localparam logic [OP_W-1:0] OP_SORT_BLOCKED  = 4'd2;
  localparam logic [OP_W-1:0] OP_SLIDE_CLEAR   = 4'd3;
  localparam logic [OP_W-1:0] OP_END_BLOCKED   = 4'd4;
  localparam logic [OP_W-1:0] OP_HEIGHT_START  = 4'd5;
  localparam logic [OP_W-1:0] OP_HEIGHT_STOP   = 4'd6;
  localparam logic [OP_W-1:0] OP_SAMPLE        = 4'd7;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_BELT_START = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EJECT      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GATE_PASS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BELT_STOP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GREEN_OFF  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SLOW_ON    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SLOW_OFF   = 3'd6;

  // Piece classes
  localparam logic [CLS_W-1:0] CLS_HOLE  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_HIGH  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_FLAT  = 2'd2;
  localparam logic [CLS_W-1:0] CLS_UNDEF = 2'd3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_OUTER_HOLE_LOW   = 4'd0;
  localparam logic [IDX_W-1:0] REG_OUTER_HOLE_HIGH  = 4'd1;
  localparam logic [IDX_W-1:0] REG_MIDDLE_HOLE_LOW  = 4'd2;
  localparam logic [IDX_W-1:0] REG_MIDDLE_HOLE_HIGH = 4'd3;
  localparam logic [IDX_W-1:0] REG_MIDDLE_TALL_LOW  = 4'd4;
  localparam logic [IDX_W-1:0] REG_MIDDLE_TALL_HIGH = 4'd5;
  localparam logic [IDX_W-1:0] REG_FLAT_LOW         = 4'd6;
  localparam logic [IDX_W-1:0] REG_FLAT_HIGH        = 4'd7;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [CLS_W-1:0] piece_class;
    logic             last_of_run;
  } result_t;

  // Bound times window size; plus_one turns an exclusive lower bound into >=
  function automatic logic [THR_W-1:0] scale_thr(input logic [VALUE_W-1:0] v,
                                                 input logic plus_one,
                                                 input int unsigned cnt);
    logic [31:0] prod;
    prod = (32'(v) + 32'(plus_one)) * 32'(cnt);
    return prod[THR_W-1:0];
  endfunction

endpackage

[src/chsc_if.sv]
// Handshake interfaces of the conveyor height sorter control: input event,
// result command and configuration write channels. Depends on chsc_pkg.
interface chsc_item_if;
  logic                           valid;
  logic                           ready;
  logic [chsc_pkg::OP_W-1:0]      operation;
  logic [chsc_pkg::VALUE_W-1:0]   sample_value;
  modport source (output valid, operation, sample_value, input ready);
  modport sink   (input valid, operation, sample_value, output ready);
endinterface

interface chsc_result_if;
  logic                           valid;
  logic                           ready;
  logic [chsc_pkg::CMD_W-1:0]     command;
  logic [chsc_pkg::CLS_W-1:0]     piece_class;
  logic                           last_of_run;
  modport source (output valid, command, piece_class, last_of_run, input ready);
  modport sink   (input valid, command, piece_class, last_of_run, output ready);
endinterface

interface chsc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [chsc_pkg::IDX_W-1:0]     index;
  logic [chsc_pkg::VALUE_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/conveyor_height_sorter_control.sv]
// Top level of the conveyor height sorter control: event decode, height
// window sums, classifier and a four-entry result queue.
// Depends on chsc_pkg and the interfaces in chsc_if.sv.

// Each accepted event is handled in the cycle it is accepted: the window sums,
// sample count and piece class update at that edge, and the zero, one or two
// commands it causes are written into a four-entry result queue at the same
// edge, each result carrying the class as it stands after the event. An event
// is taken in every cycle in which the queue has room for two results, so
// events arrive one per cycle; events that cause two commands (slide clear,
// end blocked) write two results into the queue. Results are registered in the
// queue before they reach the output. Thresholds are held pre-multiplied by
// the window sizes, so classification needs no divider; configuration writes
// are always accepted and take effect on the next cycle.
module conveyor_height_sorter_control (
  input  logic           clk,
  input  logic           rst,
  chsc_item_if.sink      item_in,
  chsc_result_if.source  result_out,
  chsc_cfg_if.sink       cfg
);
  import chsc_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // Scaled threshold registers
  logic [THR_W-1:0] oh_lo, oh_hi;        // outer hole band, outer scale
  logic [THR_W-1:0] mh_lo, mh_hi;        // middle hole band, middle scale
  logic [THR_W-1:0] mt_lo, mt_hi;        // middle tall band, middle scale
  logic [THR_W-1:0] fo_lo, fo_hi;        // flat band, outer scale
  logic [THR_W-1:0] fm_lo, fm_hi;        // flat band, middle scale

  // Measurement state
  logic [COUNT_W-1:0] sample_count, sample_count_next;
  logic [SUM_W-1:0]   outer_sum, outer_sum_next;
  logic [SUM_W-1:0]   middle_sum, middle_sum_next;
  logic [CLS_W-1:0]   piece_type, piece_type_next;

  // Result queue
  result_t            queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [FILL_W-1:0]  fill;

  logic               accept, pop;
  logic [1:0]         n_res;
  logic [CMD_W-1:0]   cmd0, cmd1;
  logic [CLS_W-1:0]   cls_new;
  logic [VALUE_W-1:0] smp;
  logic [WIN_W-1:0]   cnt_w;
  logic [SUM_W:0]     outer_add, middle_add;
  logic [THR_W-1:0]   os, ms;
  logic               o_hole_band, o_flat_band, m_hole_band, m_tall_band, m_flat_band;

  assign accept = item_in.valid && item_in.ready;
  assign pop    = result_out.valid && result_out.ready;

  assign item_in.ready = (fill <= FILL_W'(QUEUE_DEPTH - 2));
  assign cfg.ready     = 1'b1;

  // Configuration writes: store bounds pre-scaled
  always_ff @(posedge clk) begin
    if (rst) begin
      oh_lo <= scale_thr(12'd2100, 1'b1, OUTER_COUNT);
      oh_hi <= scale_thr(12'd2400, 1'b0, OUTER_COUNT);
      mh_lo <= scale_thr(12'd2900, 1'b1, MIDDLE_COUNT);
      mh_hi <= scale_thr(12'd3250, 1'b0, MIDDLE_COUNT);
      mt_lo <= scale_thr(12'd2100, 1'b1, MIDDLE_COUNT);
      mt_hi <= scale_thr(12'd2300, 1'b0, MIDDLE_COUNT);
      fo_lo <= scale_thr(12'd2400, 1'b1, OUTER_COUNT);
      fo_hi <= scale_thr(12'd2599, 1'b0, OUTER_COUNT);
      fm_lo <= scale_thr(12'd2400, 1'b1, MIDDLE_COUNT);
      fm_hi <= scale_thr(12'd2599, 1'b0, MIDDLE_COUNT);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_OUTER_HOLE_LOW:   oh_lo <= scale_thr(cfg.data, 1'b1, OUTER_COUNT);
        REG_OUTER_HOLE_HIGH:  oh_hi <= scale_thr(cfg.data, 1'b0, OUTER_COUNT);
        REG_MIDDLE_HOLE_LOW:  mh_lo <= scale_thr(cfg.data, 1'b1, MIDDLE_COUNT);
        REG_MIDDLE_HOLE_HIGH: mh_hi <= scale_thr(cfg.data, 1'b0, MIDDLE_COUNT);
        REG_MIDDLE_TALL_LOW:  mt_lo <= scale_thr(cfg.data, 1'b1, MIDDLE_COUNT);
        REG_MIDDLE_TALL_HIGH: mt_hi <= scale_thr(cfg.data, 1'b0, MIDDLE_COUNT);
        REG_FLAT_LOW: begin
          fo_lo <= scale_thr(cfg.data, 1'b1, OUTER_COUNT);
          fm_lo <= scale_thr(cfg.data, 1'b1, MIDDLE_COUNT);
        end
        REG_FLAT_HIGH: begin
          fo_hi <= scale_thr(cfg.data, 1'b0, OUTER_COUNT);
          fm_hi <= scale_thr(cfg.data, 1'b0, MIDDLE_COUNT);
        end
        default: ;
      endcase
    end
  end

  // Band checks on the sums against scaled bounds
  assign os = THR_W'(outer_sum);
  assign ms = THR_W'(middle_sum);
  assign o_hole_band = (os >= oh_lo) && (os < oh_hi);
  assign o_flat_band = (os >= fo_lo) && (os < fo_hi);
  assign m_hole_band = (ms >= mh_lo) && (ms < mh_hi);
  assign m_tall_band = (ms >= mt_lo) && (ms < mt_hi);
  assign m_flat_band = (ms >= fm_lo) && (ms < fm_hi);

  always_comb begin
    if (o_hole_band) begin
      if (m_hole_band)      cls_new = CLS_HOLE;
      else if (m_tall_band) cls_new = CLS_HIGH;
      else                  cls_new = CLS_UNDEF;
    end else if (o_flat_band) begin
      cls_new = m_flat_band ? CLS_FLAT : CLS_UNDEF;
    end else begin
      cls_new = CLS_UNDEF;
    end
  end

  // Saturating window adds
  assign smp        = item_in.sample_value & SAMPLE_MASK;
  assign cnt_w      = WIN_W'(sample_count);
  assign outer_add  = {1'b0, outer_sum} + (SUM_W + 1)'(smp);
  assign middle_add = {1'b0, middle_sum} + (SUM_W + 1)'(smp);

  // Event decode: next state and commands
  always_comb begin
    sample_count_next = sample_count;
    outer_sum_next    = outer_sum;
    middle_sum_next   = middle_sum;
    piece_type_next   = piece_type;
    n_res             = 2'd0;
    cmd0              = CMD_BELT_START;
    cmd1              = CMD_GREEN_OFF;
    case (item_in.operation)
      OP_START_BLOCKED: begin
        n_res = 2'd1;
        cmd0  = CMD_BELT_START;
      end
      OP_SORT_CLEAR: begin
        n_res = 2'd1;
        cmd0  = CMD_EJECT;
      end
      OP_SORT_BLOCKED: begin
        n_res = (piece_type != CLS_FLAT) ? 2'd1 : 2'd0;
        cmd0  = CMD_GATE_PASS;
      end
      OP_SLIDE_CLEAR, OP_END_BLOCKED: begin
        n_res = 2'd2;
        cmd0  = CMD_BELT_STOP;
        cmd1  = CMD_GREEN_OFF;
      end
      OP_HEIGHT_START: begin
        sample_count_next = '0;
        outer_sum_next    = '0;
        middle_sum_next   = '0;
        n_res             = 2'd1;
        cmd0              = CMD_SLOW_ON;
      end
      OP_HEIGHT_STOP: begin
        piece_type_next = cls_new;
        n_res           = 2'd1;
        cmd0            = CMD_SLOW_OFF;
      end
      OP_SAMPLE: begin
        if (sample_count < SAMPLE_LIMIT) begin
          if (cnt_w < OUTER_END) begin
            outer_sum_next = outer_add[SUM_W] ? SUM_MAX : outer_add[SUM_W-1:0];
          end
          if (cnt_w >= MIDDLE_BEGIN && cnt_w < MIDDLE_END) begin
            middle_sum_next = middle_add[SUM_W] ? SUM_MAX : middle_add[SUM_W-1:0];
          end
        end
        if (sample_count < COUNT_MAX) begin
          sample_count_next = sample_count + 8'd1;
        end
      end
      default: ;
    endcase
  end

  // Measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      outer_sum    <= '0;
      middle_sum   <= '0;
      piece_type   <= CLS_UNDEF;
    end else if (accept) begin
      sample_count <= sample_count_next;
      outer_sum    <= outer_sum_next;
      middle_sum   <= middle_sum_next;
      piece_type   <= piece_type_next;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      queue[wr_ptr] <= '{command: cmd0, piece_class: piece_type_next,
                         last_of_run: (n_res == 2'd1)};
    end
    if (accept && n_res == 2'd2) begin
      queue[wr_ptr + PTR_W'(1)] <= '{command: cmd1, piece_class: piece_type_next,
                                     last_of_run: 1'b1};
    end
  end

  // Result queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + PTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill <= fill + (accept ? FILL_W'(n_res) : FILL_W'(0)) - FILL_W'(pop);
    end
  end

  assign result_out.valid       = (fill != '0);
  assign result_out.command     = queue[rd_ptr].command;
  assign result_out.piece_class = queue[rd_ptr].piece_class;
  assign result_out.last_of_run = queue[rd_ptr].last_of_run;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_hstart_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && item_in.operation == OP_HEIGHT_START)
    |=> (sample_count == '0 && outer_sum == '0 && middle_sum == '0))
    else $error("height start did not clear the measurement");

  a_stop_not_last: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.command == CMD_BELT_STOP) |-> !result_out.last_of_run)
    else $error("belt stop marked as last of run");

  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (!accept && pop) |=> (fill == $past(fill) - FILL_W'(1)))
    else $error("queue fill level lost track of a pop");

endmodule

[tb/sv/chsc_tb_pkg.sv]
`timescale 1ns / 100ps
// Shared testbench types for the conveyor height sorter control: the set of
// classifier thresholds and its reset value. Depends on chsc_pkg.
package chsc_tb_pkg;
  import chsc_pkg::*;

  // One full set of classifier thresholds, all bounds exclusive
  typedef struct packed {
    logic [VALUE_W-1:0] outer_lo;
    logic [VALUE_W-1:0] outer_hi;
    logic [VALUE_W-1:0] hole_lo;
    logic [VALUE_W-1:0] hole_hi;
    logic [VALUE_W-1:0] tall_lo;
    logic [VALUE_W-1:0] tall_hi;
    logic [VALUE_W-1:0] flat_lo;
    logic [VALUE_W-1:0] flat_hi;
  } band_set_t;

  localparam band_set_t RESET_BANDS = '{
    outer_lo: 12'd2100, outer_hi: 12'd2400,
    hole_lo:  12'd2900, hole_hi:  12'd3250,
    tall_lo:  12'd2100, tall_hi:  12'd2300,
    flat_lo:  12'd2400, flat_hi:  12'd2599
  };

endpackage

[tb/sv/chsc_command_checker.sv]
`timescale 1ns / 100ps
// Command checker for the conveyor height sorter control: watches the event,
// command and threshold channels, predicts the commands and compares them.
// Depends on chsc_pkg, chsc_tb_pkg and the interfaces in chsc_if.sv.
module chsc_command_checker (
  input  logic   clk,
  input  logic   rst,
  chsc_item_if   item_mon,
  chsc_result_if result_mon,
  chsc_cfg_if    cfg_mon,
  output int     errors,
  output int     pending
);
  import chsc_pkg::*;
  import chsc_tb_pkg::*;

  localparam int REPORT_LIMIT = 40;

  // Predicted block state
  band_set_t          bands;
  logic [COUNT_W-1:0] n_samples;
  logic [SUM_W-1:0]   outer_acc;
  logic [SUM_W-1:0]   middle_acc;
  logic [CLS_W-1:0]   piece_now;
  result_t            expected_cmds[$];

  task automatic report_mismatch(input string msg);
    if (errors < REPORT_LIMIT) begin
      $display("%0t: %s", $time, msg);
    end
    errors++;
  endtask

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [VALUE_W-1:0] v);
    logic [SUM_W:0] wide;
    wide = {1'b0, acc} + (SUM_W+1)'(v);
    return (wide > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : wide[SUM_W-1:0];
  endfunction

  function automatic logic in_band(input int unsigned v, input logic [VALUE_W-1:0] lo,
                                   input logic [VALUE_W-1:0] hi);
    return (v > int'(lo)) && (v < int'(hi));
  endfunction

  // Truncated means of both windows against the threshold bands
  function automatic logic [CLS_W-1:0] classify_piece();
    int unsigned outer_mean;
    int unsigned middle_mean;
    outer_mean  = int'(outer_acc) / OUTER_COUNT;
    middle_mean = int'(middle_acc) / MIDDLE_COUNT;
    if (in_band(outer_mean, bands.outer_lo, bands.outer_hi)) begin
      if (in_band(middle_mean, bands.hole_lo, bands.hole_hi)) return CLS_HOLE;
      if (in_band(middle_mean, bands.tall_lo, bands.tall_hi)) return CLS_HIGH;
      return CLS_UNDEF;
    end
    if (in_band(outer_mean, bands.flat_lo, bands.flat_hi)) begin
      return in_band(middle_mean, bands.flat_lo, bands.flat_hi) ? CLS_FLAT : CLS_UNDEF;
    end
    return CLS_UNDEF;
  endfunction

  // Update the predicted state for one event and queue the commands it causes
  task automatic predict_commands(input logic [OP_W-1:0] op,
                                  input logic [VALUE_W-1:0] value);
    logic [CMD_W-1:0]   cmds [2];
    logic [VALUE_W-1:0] smp;
    int                 n;
    n = 0;
    case (op)
      OP_START_BLOCKED: begin
        cmds[n] = CMD_BELT_START; n++;
      end
      OP_SORT_CLEAR: begin
        cmds[n] = CMD_EJECT; n++;
      end
      OP_SORT_BLOCKED: begin
        // flat pieces go down the slide, everything else passes the gate
        if (piece_now != CLS_FLAT) begin
          cmds[n] = CMD_GATE_PASS; n++;
        end
      end
      OP_SLIDE_CLEAR, OP_END_BLOCKED: begin
        cmds[n] = CMD_BELT_STOP; n++;
        cmds[n] = CMD_GREEN_OFF; n++;
      end
      OP_HEIGHT_START: begin
        n_samples  = '0;
        outer_acc  = '0;
        middle_acc = '0;
        cmds[n] = CMD_SLOW_ON; n++;
      end
      OP_HEIGHT_STOP: begin
        cmds[n] = CMD_SLOW_OFF; n++;
        piece_now = classify_piece();
      end
      OP_SAMPLE: begin
        smp = value & SAMPLE_MASK;
        if (n_samples < SAMPLE_LIMIT) begin
          if (n_samples < OUTER_COUNT) outer_acc = sat_add(outer_acc, smp);
          if (n_samples >= MIDDLE_START && n_samples < MIDDLE_START + MIDDLE_COUNT)
            middle_acc = sat_add(middle_acc, smp);
        end
        if (n_samples < COUNT_MAX) n_samples++;
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      expected_cmds.push_back('{command: cmds[k], piece_class: piece_now,
                                last_of_run: (k == n - 1)});
    end
  endtask

  // Sample all channels on the rising edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      bands      = RESET_BANDS;
      n_samples  = '0;
      outer_acc  = '0;
      middle_acc = '0;
      piece_now  = CLS_UNDEF;
      errors     = 0;
      expected_cmds.delete();
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("unexpected command %0d, nothing pending",
                                    result_mon.command));
        end else begin
          want = expected_cmds.pop_front();
          if (result_mon.command !== want.command)
            report_mismatch($sformatf("command mismatch: got %0d, expected %0d",
                                      result_mon.command, want.command));
          if (result_mon.piece_class !== want.piece_class)
            report_mismatch($sformatf("piece_class mismatch: got %0d, expected %0d",
                                      result_mon.piece_class, want.piece_class));
          if (result_mon.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run mismatch: got %0d, expected %0d",
                                      result_mon.last_of_run, want.last_of_run));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_OUTER_HOLE_LOW:   bands.outer_lo = cfg_mon.data;
          REG_OUTER_HOLE_HIGH:  bands.outer_hi = cfg_mon.data;
          REG_MIDDLE_HOLE_LOW:  bands.hole_lo  = cfg_mon.data;
          REG_MIDDLE_HOLE_HIGH: bands.hole_hi  = cfg_mon.data;
          REG_MIDDLE_TALL_LOW:  bands.tall_lo  = cfg_mon.data;
          REG_MIDDLE_TALL_HIGH: bands.tall_hi  = cfg_mon.data;
          REG_FLAT_LOW:         bands.flat_lo  = cfg_mon.data;
          REG_FLAT_HIGH:        bands.flat_hi  = cfg_mon.data;
          default: ;
        endcase
      end
      if (item_mon.valid && item_mon.ready)
        predict_commands(item_mon.operation, item_mon.sample_value);
    end
    pending = expected_cmds.size();
  end

endmodule

[tb/sv/conveyor_height_sorter_control_tb.sv]
`timescale 1ns / 100ps
// Top of the conveyor height sorter control testbench: clock, reset, event
// and threshold stimulus, command back-pressure and the final verdict.
// Depends on chsc_pkg, chsc_tb_pkg, chsc_if.sv and chsc_command_checker.
module conveyor_height_sorter_control_tb;
  import chsc_pkg::*;
  import chsc_tb_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 10;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 260;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 10;
  localparam logic [OP_W-1:0]  OP_UNUSED  = 4'd8;
  localparam logic [IDX_W-1:0] REG_UNUSED = 4'd8;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_ALTERNATE} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_fire = 1'b0;
  logic cfg_fire = 1'b0;
  int   errors;
  int   pending;

  chsc_item_if   item_ch ();
  chsc_result_if result_ch ();
  chsc_cfg_if    cfg_ch ();

  conveyor_height_sorter_control dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_ch),
    .result_out (result_ch),
    .cfg        (cfg_ch)
  );

  chsc_command_checker cmd_check (
    .clk        (clk),
    .rst        (rst),
    .item_mon   (item_ch),
    .result_mon (result_ch),
    .cfg_mon    (cfg_ch),
    .errors     (errors),
    .pending    (pending)
  );

  always #HALF_PERIOD clk = ~clk;

  // Transaction flags seen at the rising edge, read by the drivers at the falling edge
  always @(posedge clk) begin
    item_fire <= item_ch.valid && item_ch.ready;
    cfg_fire  <= cfg_ch.valid && cfg_ch.ready;
  end

  band_set_t bands = RESET_BANDS;
  int        burst_left = 0;
  int        items_sent = 0;
  bit        hold_req = 1'b0;

  // Present one event; bursts of random length separated by random gaps
  task automatic send_event(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 40);
    end
    burst_left--;
    item_ch.operation    = op;
    item_ch.sample_value = value;
    item_ch.valid        = 1'b1;
    do @(negedge clk); while (!item_fire);
    if (op <= OP_SAMPLE) items_sent++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do @(negedge clk); while (!cfg_fire);
  endtask

  task automatic load_bands(input band_set_t b);
    write_reg(REG_OUTER_HOLE_LOW, b.outer_lo);
    write_reg(REG_OUTER_HOLE_HIGH, b.outer_hi);
    write_reg(REG_MIDDLE_HOLE_LOW, b.hole_lo);
    write_reg(REG_MIDDLE_HOLE_HIGH, b.hole_hi);
    write_reg(REG_MIDDLE_TALL_LOW, b.tall_lo);
    write_reg(REG_MIDDLE_TALL_HIGH, b.tall_hi);
    write_reg(REG_FLAT_LOW, b.flat_lo);
    write_reg(REG_FLAT_HIGH, b.flat_hi);
    cfg_ch.valid = 1'b0;
    bands = b;
  endtask

  // Wait until every command has come out and the block has settled
  task automatic wait_idle();
    item_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] nudge(input logic [VALUE_W-1:0] v);
    return VALUE_W'(int'(v) + $urandom_range(0, 100) - 50);
  endfunction

  function automatic logic [VALUE_W-1:0] band_top(input logic [VALUE_W-1:0] lo);
    int hi;
    hi = int'(lo) + $urandom_range(2, 500);
    return (hi > 4095) ? 12'd4095 : VALUE_W'(hi);
  endfunction

  // A level strictly inside a band, or anything if the band is empty
  function automatic int level_in(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi);
    if (int'(hi) > int'(lo) + 1) return $urandom_range(int'(lo) + 1, int'(hi) - 1);
    return $urandom_range(0, 4095);
  endfunction

  function automatic logic [VALUE_W-1:0] jitter(input int level);
    int v;
    v = level + $urandom_range(0, 8) - 4;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return VALUE_W'(v);
  endfunction

  // One piece passing the belt: profile shaped toward a class, mostly well formed
  task automatic run_piece();
    int kind;
    int n;
    int r;
    int outer_level;
    int middle_level;
    kind = $urandom_range(0, 4);
    case (kind)
      0: begin
        outer_level  = level_in(bands.outer_lo, bands.outer_hi);
        middle_level = level_in(bands.hole_lo, bands.hole_hi);
      end
      1: begin
        outer_level  = level_in(bands.outer_lo, bands.outer_hi);
        middle_level = level_in(bands.tall_lo, bands.tall_hi);
      end
      2: begin
        outer_level  = level_in(bands.flat_lo, bands.flat_hi);
        middle_level = level_in(bands.flat_lo, bands.flat_hi);
      end
      3: begin
        outer_level  = level_in(bands.outer_lo, bands.outer_hi);
        middle_level = $urandom_range(0, 4095);
      end
      default: begin
        outer_level  = $urandom_range(0, 4095);
        middle_level = $urandom_range(0, 4095);
      end
    endcase
    // mostly full profiles, some cut short, some running past the sample limit
    r = $urandom_range(0, 19);
    if (r == 0) n = $urandom_range(0, 119);
    else if (r == 1) n = $urandom_range(190, 270);
    else n = $urandom_range(120, 135);

    if ($urandom_range(0, 9) != 0) send_event(OP_START_BLOCKED, VALUE_W'($urandom));
    if ($urandom_range(0, 9) != 0) send_event(OP_HEIGHT_START, VALUE_W'($urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 59) == 0)
        send_event(OP_W'($urandom_range(0, 15)), VALUE_W'($urandom));
      if (i < OUTER_COUNT)
        send_event(OP_SAMPLE, jitter(outer_level));
      else if (i >= MIDDLE_START && i < MIDDLE_START + MIDDLE_COUNT)
        send_event(OP_SAMPLE, jitter(middle_level));
      else
        send_event(OP_SAMPLE, VALUE_W'($urandom));
    end
    send_event(OP_HEIGHT_STOP, VALUE_W'($urandom));
    if ($urandom_range(0, 19) == 0) send_event(OP_HEIGHT_STOP, VALUE_W'($urandom));
    send_event(OP_SORT_BLOCKED, VALUE_W'($urandom));
    if ($urandom_range(0, 1) == 0) send_event(OP_SORT_CLEAR, VALUE_W'($urandom));
    send_event($urandom_range(0, 1) ? OP_SLIDE_CLEAR : OP_END_BLOCKED, VALUE_W'($urandom));
  endtask

  // Receiver: stall pattern changes after each span of random length; long hold-off on request
  initial begin
    rx_mode_t mode;
    int       span;
    int       held;
    bit       toggle;
    result_ch.ready = 1'b0;
    toggle = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          result_ch.ready = 1'b0;
          held = 0;
          while (held < HOLD_CYCLES) begin
            @(negedge clk);
            held++;
          end
        end
        toggle = ~toggle;
        case (mode)
          RX_OPEN:      result_ch.ready = 1'b1;
          RX_HALF:      result_ch.ready = $urandom_range(0, 1);
          RX_SPARSE:    result_ch.ready = ($urandom_range(0, 4) == 0);
          RX_ALTERNATE: result_ch.ready = toggle;
          default:      result_ch.ready = 1'b1;
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin
    band_set_t b;
    int        target;
    int        waited;
    item_ch.valid        = 1'b0;
    item_ch.operation    = OP_START_BLOCKED;
    item_ch.sample_value = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_OUTER_HOLE_LOW;
    cfg_ch.data          = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every event, field extremes, stop without start, missing samples
    send_event(OP_START_BLOCKED, 12'd0);
    send_event(OP_SORT_CLEAR, 12'd4095);
    send_event(OP_SORT_BLOCKED, 12'd0);
    send_event(OP_SLIDE_CLEAR, 12'd4095);
    send_event(OP_END_BLOCKED, 12'd0);
    send_event(OP_HEIGHT_STOP, 12'd4095);
    send_event(OP_HEIGHT_START, 12'd0);
    send_event(OP_SAMPLE, 12'd4095);
    send_event(OP_SAMPLE, 12'd0);
    send_event(OP_SAMPLE, 12'd4095);
    send_event(OP_HEIGHT_STOP, 12'd0);
    send_event(OP_HEIGHT_STOP, 12'd4095);
    send_event(OP_UNUSED, 12'd4095);
    send_event(OP_UNUSED | OP_SAMPLE, 12'd0);
    send_event(OP_SORT_BLOCKED, 12'd4095);
    send_event(OP_HEIGHT_START, 12'd4095);
    send_event(OP_SAMPLE, 12'd2500);
    send_event(OP_HEIGHT_STOP, 12'd0);
    send_event(OP_END_BLOCKED, 12'd4095);

    // Random phases, each under its own threshold setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: b = RESET_BANDS;
        1: begin
          b.outer_lo = nudge(RESET_BANDS.outer_lo);
          b.outer_hi = nudge(RESET_BANDS.outer_hi);
          b.hole_lo  = nudge(RESET_BANDS.hole_lo);
          b.hole_hi  = nudge(RESET_BANDS.hole_hi);
          b.tall_lo  = nudge(RESET_BANDS.tall_lo);
          b.tall_hi  = nudge(RESET_BANDS.tall_hi);
          b.flat_lo  = nudge(RESET_BANDS.flat_lo);
          b.flat_hi  = nudge(RESET_BANDS.flat_hi);
        end
        2: b = '0;
        3: b = '{outer_lo: 12'd0, outer_hi: 12'd4095, hole_lo: 12'd0, hole_hi: 12'd4095,
                 tall_lo: 12'd0, tall_hi: 12'd4095, flat_lo: 12'd0, flat_hi: 12'd4095};
        4: begin
          // empty outer band so the flat band decides
          b = '{outer_lo: 12'd4095, outer_hi: 12'd0, hole_lo: 12'd0, hole_hi: 12'd0,
                tall_lo: 12'd0, tall_hi: 12'd0, flat_lo: 12'd0, flat_hi: 12'd4095};
        end
        default: begin
          write_reg(REG_UNUSED | IDX_W'($urandom_range(0, 7)), VALUE_W'($urandom));
          b.outer_lo = VALUE_W'($urandom_range(1500, 3500));
          b.outer_hi = band_top(b.outer_lo);
          b.hole_lo  = VALUE_W'($urandom_range(1500, 3500));
          b.hole_hi  = band_top(b.hole_lo);
          b.tall_lo  = VALUE_W'($urandom_range(1500, 3500));
          b.tall_hi  = band_top(b.tall_lo);
          b.flat_lo  = VALUE_W'($urandom_range(1500, 3500));
          b.flat_hi  = band_top(b.flat_lo);
        end
      endcase
      load_bands(b);
      if (p == 1 || p == 4) hold_req = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_piece();
    end

    // Drain and verdict
    item_ch.valid = 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending != 0) $display("%0d expected commands never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("conveyor_height_sorter_control regression: pass");
    end else begin
      $display("conveyor_height_sorter_control regression: fail");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4000000;
    $display("run limit reached");
    $display("conveyor_height_sorter_control regression: fail");
    $finish;
  end

endmodule

[sim.f]
src/chsc_pkg.sv
src/chsc_if.sv
src/conveyor_height_sorter_control.sv
tb/sv/chsc_tb_pkg.sv
tb/sv/chsc_command_checker.sv
tb/sv/conveyor_height_sorter_control_tb.sv
